/* hw/rtl/ssifp_pkg.sv */
// Package: constants and types for the storage image format patcher.
package ssifp_pkg;

  localparam logic [31:0] MAGIC_WORD          = 32'h0723_0203;
  localparam logic [15:0] OP_CAPABILITY       = 16'd17;
  localparam logic [15:0] OP_TYPE_IMAGE       = 16'd25;
  localparam logic [31:0] CAP_SHADER          = 32'd1;
  localparam logic [31:0] CAP_EXT_FORMATS     = 32'd49;
  localparam logic [31:0] CAP_WRITE_NO_FORMAT = 32'd56;
  localparam logic [31:0] FMT_R8_SNORM        = 32'd20;
  localparam logic [31:0] DIM_STORAGE         = 32'd2;

  localparam logic [2:0] HEADER_WORDS    = 3'd5;
  localparam logic [3:0] OFFSET_MAX      = 4'd9;
  localparam logic [3:0] OFFSET_CAP      = 4'd1;
  localparam logic [3:0] OFFSET_SAMPLED  = 4'd7;
  localparam logic [3:0] OFFSET_FORMAT   = 4'd8;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    StOk       = 3'd0,
    StShort    = 3'd1,
    StBadMagic = 3'd2,
    StBadLen   = 3'd3,
    StNoImage  = 3'd4,
    StNoCap    = 3'd5
  } status_e;

endpackage

/* hw/rtl/ssifp_if.sv */
// Interfaces: word input, patched word output and format register write channels.
interface ssifp_in_if import ssifp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word;
  logic              last;

  modport source (output valid, output word, output last, input ready);
  modport sink (input valid, input word, input last, output ready);
endinterface

interface ssifp_out_if import ssifp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   word_out;
  logic                last_out;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output word_out, output last_out, output status, input ready);
  modport sink (input valid, input word_out, input last_out, input status, output ready);
endinterface

interface ssifp_cfg_if import ssifp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] image_format;

  modport source (output valid, output image_format, input ready);
  modport sink (input valid, input image_format, output ready);
endinterface

/* hw/rtl/spirv_storage_image_format_patcher.sv */
// Top level: SPIR-V word stream patcher for storage image formats.
//
//  channel | dir | payload                     | transfer when
//  in_i    | in  | word[31:0], last            | in_i.valid & in_i.ready
//  out_o   | out | word_out[31:0], last_out,   | out_o.valid & out_o.ready
//          |     | status[2:0]                 |
//  cfg_i   | in  | image_format[31:0]          | cfg_i.valid (ready tied high)
//
//  One word per cycle while out_o is not stalled; each accepted word is written into the output register.
//  Throughput is set by the single output register: in_i.ready is high when it is
//  empty or being drained in the same cycle.
//  Reset clears stream state, the format register and the output valid.
//  A stall on out_o holds the result and blocks new input transfers.
module spirv_storage_image_format_patcher import ssifp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssifp_in_if.sink    in_i,
  ssifp_out_if.source out_o,
  ssifp_cfg_if.sink   cfg_i
);

  logic [WORD_W-1:0] fmt_q;

  logic [2:0]  hc_q, hc_d;
  logic [15:0] wl_q, wl_d;
  logic [3:0]  wo_q, wo_d;
  logic        in_cap_q, in_cap_d;
  logic        in_img_q, in_img_d;
  logic        storage_q, storage_d;
  logic        patched_q, patched_d;
  logic        cap_ok_q, cap_ok_d;
  status_e     err_q, err_d;

  logic              out_valid_q;
  logic [WORD_W-1:0] out_word_q;
  logic              out_last_q;
  status_e           out_status_q;

  logic              in_fire;
  logic [WORD_W-1:0] word_d;
  status_e           status_d;
  logic [15:0]       count;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign count       = in_i.word[31:16];

  always_comb begin
    hc_d      = hc_q;
    wl_d      = wl_q;
    wo_d      = wo_q;
    in_cap_d  = in_cap_q;
    in_img_d  = in_img_q;
    storage_d = storage_q;
    patched_d = patched_q;
    cap_ok_d  = cap_ok_q;
    err_d     = err_q;
    word_d    = in_i.word;

    if (hc_q < HEADER_WORDS) begin
      if (hc_q == 3'd0 && in_i.word != MAGIC_WORD) begin
        err_d = StBadMagic;
      end
      hc_d = hc_q + 3'd1;
    end else if (err_q != StOk) begin
      // stream is dead: pass through
    end else if (wl_q == 16'd0) begin
      if (count == 16'd0) begin
        err_d = StBadLen;
      end else begin
        wl_d      = count - 16'd1;
        wo_d      = 4'd0;
        in_cap_d  = (in_i.word[15:0] == OP_CAPABILITY);
        in_img_d  = (in_i.word[15:0] == OP_TYPE_IMAGE);
        storage_d = 1'b0;
      end
    end else begin
      wo_d = (wo_q < OFFSET_MAX) ? wo_q + 4'd1 : wo_q;
      wl_d = wl_q - 16'd1;
      if (in_cap_q && wo_d == OFFSET_CAP) begin
        if (in_i.word == CAP_EXT_FORMATS) begin
          cap_ok_d = 1'b1;
        end
        if (in_i.word == CAP_WRITE_NO_FORMAT) begin
          if (fmt_q == FMT_R8_SNORM) begin
            word_d   = CAP_EXT_FORMATS;
            cap_ok_d = 1'b1;
          end else begin
            word_d = CAP_SHADER;
          end
        end
      end
      if (in_img_q) begin
        if (wo_d == OFFSET_SAMPLED) begin
          storage_d = (in_i.word == DIM_STORAGE);
        end else if (wo_d == OFFSET_FORMAT && storage_q) begin
          word_d    = fmt_q;
          patched_d = 1'b1;
        end
      end
    end

    status_d = err_d;
    if (in_i.last) begin
      if (hc_d < HEADER_WORDS) begin
        status_d = StShort;
      end else if (err_d != StOk) begin
        status_d = err_d;
      end else if (wl_d != 16'd0) begin
        status_d = StBadLen;
      end else if (!patched_d) begin
        status_d = StNoImage;
      end else if (!cap_ok_d && fmt_q == FMT_R8_SNORM) begin
        status_d = StNoCap;
      end else begin
        status_d = StOk;
      end
      // end of module: clear stream state
      hc_d      = 3'd0;
      wl_d      = 16'd0;
      wo_d      = 4'd0;
      in_cap_d  = 1'b0;
      in_img_d  = 1'b0;
      storage_d = 1'b0;
      patched_d = 1'b0;
      cap_ok_d  = 1'b0;
      err_d     = StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= '0;
      hc_q        <= 3'd0;
      wl_q        <= 16'd0;
      wo_q        <= 4'd0;
      in_cap_q    <= 1'b0;
      in_img_q    <= 1'b0;
      storage_q   <= 1'b0;
      patched_q   <= 1'b0;
      cap_ok_q    <= 1'b0;
      err_q       <= StOk;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        fmt_q <= cfg_i.image_format;
      end
      if (in_fire) begin
        hc_q      <= hc_d;
        wl_q      <= wl_d;
        wo_q      <= wo_d;
        in_cap_q  <= in_cap_d;
        in_img_q  <= in_img_d;
        storage_q <= storage_d;
        patched_q <= patched_d;
        cap_ok_q  <= cap_ok_d;
        err_q     <= err_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_word_q   <= word_d;
      out_last_q   <= in_i.last;
      out_status_q <= status_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.word_out = out_word_q;
  assign out_o.last_out = out_last_q;
  assign out_o.status   = out_status_q;

  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |-> !in_fire)
    else $error("input accepted while result stalled");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.last |=> hc_q == 3'd0 && err_q == StOk && wl_q == 16'd0)
    else $error("stream state not cleared after last word");

  a_sticky_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q == StOk || err_q == StBadMagic || err_q == StBadLen)
    else $error("sticky error holds an end-only code");

  a_counter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hc_q <= HEADER_WORDS && wo_q <= OFFSET_MAX)
    else $error("header or offset counter out of range");

  a_err_stops_tracking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !in_i.last && err_q != StOk && hc_q == HEADER_WORDS |=> $stable(wl_q))
    else $error("instruction tracking moved after an error");

endmodule

/* dv/spirv_storage_image_format_patcher_tb.sv */
// Testbench: SPIR-V storage image format patcher checked word by word against a local predictor and typed rows.
module spirv_storage_image_format_patcher_tb;
  import ssifp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } stim_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
    status_e           status;
  } patch_res_t;

  typedef enum logic {RowWord, RowCfg} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [WORD_W-1:0] word;
    logic              last;
    bit                typed;
    logic [WORD_W-1:0] exp_word;
    status_e           exp_st;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  ssifp_in_if  in_if ();
  ssifp_out_if out_if ();
  ssifp_cfg_if cfg_if ();

  spirv_storage_image_format_patcher i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // predictor state
  logic [WORD_W-1:0] fmt_reg;
  logic [2:0]        hdr_seen;
  logic [15:0]       ins_left;
  logic [3:0]        ins_pos;
  bit                in_cap;
  bit                in_img;
  bit                img_storage;
  bit                fmt_patched;
  bit                ext_ok;
  status_e           err_code;

  patch_res_t patched_fifo[$];
  stim_t      module_words[$];
  dir_row_t   dir_rows[$];
  int         mismatch_cnt = 0;
  int         send_idle = 0;
  int         recv_stall = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("spirv_storage_image_format_patcher_tb NOT OK");
    $finish;
  end

  task automatic clear_stream_state();
    hdr_seen    = '0;
    ins_left    = '0;
    ins_pos     = '0;
    in_cap      = 1'b0;
    in_img      = 1'b0;
    img_storage = 1'b0;
    fmt_patched = 1'b0;
    ext_ok      = 1'b0;
    err_code    = StOk;
  endtask

  task automatic patch_and_grade(input logic [WORD_W-1:0] w, input logic l,
                                 output patch_res_t r);
    logic [WORD_W-1:0] ow;
    logic [15:0]       cnt;
    status_e           st;
    ow = w;
    if (hdr_seen < HEADER_WORDS) begin
      if (hdr_seen == 3'd0 && w != MAGIC_WORD) err_code = StBadMagic;
      hdr_seen = hdr_seen + 3'd1;
    end else if (err_code == StOk) begin
      if (ins_left == 16'd0) begin
        cnt = w[31:16];
        if (cnt == 16'd0) begin
          err_code = StBadLen;
        end else begin
          ins_left    = cnt - 16'd1;
          ins_pos     = '0;
          in_cap      = (w[15:0] == OP_CAPABILITY);
          in_img      = (w[15:0] == OP_TYPE_IMAGE);
          img_storage = 1'b0;
        end
      end else begin
        if (ins_pos < OFFSET_MAX) ins_pos = ins_pos + 4'd1;
        ins_left = ins_left - 16'd1;
        if (in_cap && ins_pos == OFFSET_CAP) begin
          if (w == CAP_EXT_FORMATS) ext_ok = 1'b1;
          if (w == CAP_WRITE_NO_FORMAT) begin
            ow = (fmt_reg == FMT_R8_SNORM) ? CAP_EXT_FORMATS : CAP_SHADER;
            if (ow == CAP_EXT_FORMATS) ext_ok = 1'b1;
          end
        end
        if (in_img) begin
          if (ins_pos == OFFSET_SAMPLED) begin
            img_storage = (w == DIM_STORAGE);
          end else if (ins_pos == OFFSET_FORMAT && img_storage) begin
            ow          = fmt_reg;
            fmt_patched = 1'b1;
          end
        end
      end
    end
    st = err_code;
    if (l) begin
      if (hdr_seen < HEADER_WORDS)                     st = StShort;
      else if (err_code != StOk)                       st = err_code;
      else if (ins_left != 16'd0)                      st = StBadLen;
      else if (!fmt_patched)                           st = StNoImage;
      else if (!ext_ok && fmt_reg == FMT_R8_SNORM)     st = StNoCap;
      else                                             st = StOk;
      clear_stream_state();
    end
    r.word   = ow;
    r.last   = l;
    r.status = st;
  endtask

  // entered and left at a falling edge
  task automatic drive_word(input stim_t s, input bit typed, input patch_res_t typed_res);
    patch_res_t pred;
    while ($urandom_range(99, 0) < send_idle) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.word  = s.word;
    in_if.last  = s.last;
    do @(posedge clk_i); while (!in_if.ready);
    patch_and_grade(s.word, s.last, pred);
    patched_fifo.push_back(typed ? typed_res : pred);
    @(negedge clk_i);
  endtask

  task automatic write_format(input logic [WORD_W-1:0] v);
    in_if.valid = 1'b0;
    while (patched_fifo.size() != 0) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_if.valid        = 1'b1;
    cfg_if.image_format = v;
    do @(posedge clk_i); while (!cfg_if.ready);
    fmt_reg = v;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic add_row(input row_kind_e kind, input logic [WORD_W-1:0] w, input logic l,
                         input bit typed, input logic [WORD_W-1:0] ew, input status_e est);
    dir_row_t row;
    row.kind     = kind;
    row.word     = w;
    row.last     = l;
    row.typed    = typed;
    row.exp_word = ew;
    row.exp_st   = est;
    dir_rows.push_back(row);
  endtask

  // mostly well-formed modules, some broken ones
  task automatic build_module();
    logic [WORD_W-1:0] mod[$];
    int unsigned       kind;
    int unsigned       sel;
    int unsigned       n_ins;
    int unsigned       cut;
    logic [15:0]       cnt;
    stim_t             s;
    kind = $urandom_range(99, 0);
    mod.push_back((kind < 8) ? $urandom() : MAGIC_WORD);
    repeat (4) mod.push_back($urandom());
    if (kind >= 8 && kind < 14) begin
      cut = $urandom_range(3, 0);
      while (mod.size() > cut + 1) void'(mod.pop_back());
    end else begin
      n_ins = $urandom_range(6, 1);
      repeat (n_ins) begin
        sel = $urandom_range(99, 0);
        if (sel < 35) begin
          cnt = ($urandom_range(9, 0) == 0) ? 16'd3 : 16'd2;
          mod.push_back({cnt, OP_CAPABILITY});
          repeat (cnt - 1) begin
            case ($urandom_range(3, 0))
              0: mod.push_back(CAP_WRITE_NO_FORMAT);
              1: mod.push_back(CAP_EXT_FORMATS);
              2: mod.push_back(CAP_SHADER);
              default: mod.push_back($urandom());
            endcase
          end
        end else if (sel < 75) begin
          cnt = ($urandom_range(4, 0) == 0) ? 16'($urandom_range(12, 8)) : 16'd9;
          mod.push_back({cnt, OP_TYPE_IMAGE});
          for (int k = 1; k < cnt; k++) begin
            if (k == OFFSET_SAMPLED)
              mod.push_back(($urandom_range(9, 0) < 7) ? DIM_STORAGE
                                                       : 32'($urandom_range(3, 0)));
            else
              mod.push_back(32'($urandom_range(40, 0)));
          end
        end else begin
          cnt = ($urandom_range(19, 0) == 0) ? 16'($urandom_range(65535, 1))
                                             : 16'($urandom_range(4, 1));
          mod.push_back({cnt, 16'($urandom_range(65535, 0))});
          for (int k = 1; k < cnt && k < 4; k++) mod.push_back($urandom());
        end
      end
      if (kind >= 14 && kind < 20) begin
        mod.insert($urandom_range(mod.size(), 5), {16'd0, 16'($urandom_range(65535, 0))});
      end else if (kind >= 20 && kind < 26 && mod.size() > 6) begin
        cut = $urandom_range(mod.size() - 2, 5);
        while (mod.size() > cut + 1) void'(mod.pop_back());
      end
    end
    foreach (mod[i]) begin
      s.word = mod[i];
      s.last = (i == mod.size() - 1);
      module_words.push_back(s);
    end
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready = ($urandom_range(99, 0) >= recv_stall);
    end
  end

  always @(posedge clk_i) begin
    patch_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (patched_fifo.size() == 0) begin
        $display("%0t: unexpected transfer, actual word %h last %0d status %0d", $time,
                 out_if.word_out, out_if.last_out, out_if.status);
        mismatch_cnt++;
      end else begin
        want = patched_fifo.pop_front();
        if (out_if.word_out !== want.word) begin
          $display("%0t: word_out expected %h actual %h", $time, want.word, out_if.word_out);
          mismatch_cnt++;
        end
        if (out_if.last_out !== want.last) begin
          $display("%0t: last_out expected %0d actual %0d", $time, want.last, out_if.last_out);
          mismatch_cnt++;
        end
        if (out_if.status !== 3'(want.status)) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_if.status);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    stim_t             s;
    patch_res_t        tres;
    patch_res_t        no_typed;
    logic [WORD_W-1:0] v;

    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.word          = '0;
    in_if.last          = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.image_format = '0;
    no_typed            = '{word: '0, last: 1'b0, status: StOk};
    fmt_reg             = '0;
    clear_stream_state();

    // short module, bad magic, full patch with R8Snorm, zero word count
    add_row(RowWord, MAGIC_WORD,      1'b1, 1'b1, MAGIC_WORD,      StShort);
    add_row(RowWord, 32'hFFFF_FFFF,   1'b0, 1'b1, 32'hFFFF_FFFF,   StBadMagic);
    add_row(RowWord, 32'h0000_0000,   1'b1, 1'b1, 32'h0000_0000,   StShort);
    add_row(RowCfg,  FMT_R8_SNORM,    1'b0, 1'b0, '0,              StOk);
    add_row(RowWord, MAGIC_WORD,      1'b0, 1'b0, '0,              StOk);
    add_row(RowWord, 32'h0001_0500,   1'b0, 1'b0, '0,              StOk);
    add_row(RowWord, 32'h0000_0000,   1'b0, 1'b0, '0,              StOk);
    add_row(RowWord, 32'h0000_0010,   1'b0, 1'b0, '0,              StOk);
    add_row(RowWord, 32'h0000_0000,   1'b0, 1'b0, '0,              StOk);
    add_row(RowWord, {16'd2, OP_CAPABILITY}, 1'b0, 1'b0, '0,       StOk);
    add_row(RowWord, CAP_WRITE_NO_FORMAT, 1'b0, 1'b1, CAP_EXT_FORMATS, StOk);
    add_row(RowWord, {16'd9, OP_TYPE_IMAGE}, 1'b0, 1'b0, '0,       StOk);
    add_row(RowWord, 32'd5,           1'b0, 1'b0, '0,              StOk);
    add_row(RowWord, 32'd4,           1'b0, 1'b0, '0,              StOk);
    add_row(RowWord, 32'd1,           1'b0, 1'b0, '0,              StOk);
    add_row(RowWord, 32'd0,           1'b0, 1'b0, '0,              StOk);
    add_row(RowWord, 32'd0,           1'b0, 1'b0, '0,              StOk);
    add_row(RowWord, 32'd0,           1'b0, 1'b0, '0,              StOk);
    add_row(RowWord, DIM_STORAGE,     1'b0, 1'b0, '0,              StOk);
    add_row(RowWord, 32'd3,           1'b1, 1'b1, FMT_R8_SNORM,    StOk);
    add_row(RowWord, MAGIC_WORD,      1'b0, 1'b0, '0,              StOk);
    add_row(RowWord, 32'h0001_0000,   1'b0, 1'b0, '0,              StOk);
    add_row(RowWord, 32'h0000_0000,   1'b0, 1'b0, '0,              StOk);
    add_row(RowWord, 32'h0000_0001,   1'b0, 1'b0, '0,              StOk);
    add_row(RowWord, 32'h0000_0000,   1'b0, 1'b0, '0,              StOk);
    add_row(RowWord, {16'd0, OP_CAPABILITY}, 1'b1, 1'b1, {16'd0, OP_CAPABILITY}, StBadLen);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowCfg) begin
        write_format(dir_rows[i].word);
      end else begin
        s.word      = dir_rows[i].word;
        s.last      = dir_rows[i].last;
        tres.word   = dir_rows[i].exp_word;
        tres.last   = dir_rows[i].last;
        tres.status = dir_rows[i].exp_st;
        drive_word(s, dir_rows[i].typed, tres);
      end
    end

    // phases may end mid-module, so the format also changes mid-stream
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: v = FMT_R8_SNORM;
        1: v = '1;
        2: v = '0;
        3: v = $urandom();
        default: v = $urandom_range(1, 0) ? FMT_R8_SNORM : 32'($urandom_range(40, 0));
      endcase
      write_format(v);
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 52; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 52; end
        default: begin send_idle = 29; recv_stall = 29; end
      endcase
      repeat (63) begin
        if (module_words.size() == 0) build_module();
        drive_word(module_words.pop_front(), 1'b0, no_typed);
      end
    end

    in_if.valid = 1'b0;
    while (patched_fifo.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (mismatch_cnt == 0 && patched_fifo.size() == 0) begin
      $display("spirv_storage_image_format_patcher_tb OK");
    end else begin
      $display("spirv_storage_image_format_patcher_tb NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/ssifp_pkg.sv
hw/rtl/ssifp_if.sv
hw/rtl/spirv_storage_image_format_patcher.sv
dv/spirv_storage_image_format_patcher_tb.sv
